@@ src/i2dt_pkg.sv @@
// Shared constants, types and codes for the integer to decimal text converter.
package i2dt_pkg;

   // Width of the signed integer taken from each input beat.
   localparam int VALUE_BITS = 32;

   // Decimal digits needed for the largest unsigned magnitude; 1233/4096 approximates log10(2).
   localparam int DIGIT_COUNT  = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_BITS     = 4 * DIGIT_COUNT;
   localparam int BIT_CNT_BITS = $clog2(VALUE_BITS + 1);
   localparam int DIG_CNT_BITS = $clog2(DIGIT_COUNT + 1);

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // Double dabble correction: a digit of five or more gets three added before each shift.
   localparam logic [3:0] DIGIT_FIX_LIMIT = 4'd5;
   localparam logic [3:0] DIGIT_FIX_ADD   = 4'd3;

   typedef enum logic [1:0] {
      UNIT_HOLD,
      UNIT_LOAD,
      UNIT_DABBLE,
      UNIT_NEXT_DIGIT
   } unit_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic [3:0] top_digit;
      logic       negative;
   } unit_status_type;

endpackage

@@ src/i2dt_shift_unit.sv @@
// Shared shift and add-three unit that turns the magnitude into BCD digits and shifts them out.
module i2dt_shift_unit (
   input  logic                                    clock,
   input  i2dt_pkg::unit_op_type                   op,
   input  logic signed [i2dt_pkg::VALUE_BITS-1:0]  load_value,
   output i2dt_pkg::unit_status_type               status
);

   logic [i2dt_pkg::VALUE_BITS-1:0] bin_ff, bin_in;
   logic [i2dt_pkg::BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic                            negative_ff, negative_in;
   logic [i2dt_pkg::BCD_BITS-1:0]   fixed;

   always_comb begin
      fixed = bcd_ff;
      for (int d = 0; d < i2dt_pkg::DIGIT_COUNT; d++) begin
         if (bcd_ff[4*d +: 4] >= i2dt_pkg::DIGIT_FIX_LIMIT) begin
            fixed[4*d +: 4] = bcd_ff[4*d +: 4] + i2dt_pkg::DIGIT_FIX_ADD;
         end
      end

      bin_in      = bin_ff;
      bcd_in      = bcd_ff;
      negative_in = negative_ff;
      unique case (op)
         i2dt_pkg::UNIT_HOLD: begin
         end
         i2dt_pkg::UNIT_LOAD: begin
            // The magnitude is taken as unsigned, so the most negative value is exact.
            negative_in = load_value[i2dt_pkg::VALUE_BITS-1];
            bin_in      = load_value[i2dt_pkg::VALUE_BITS-1] ? (~load_value + 1'b1)
                                                              : load_value;
            bcd_in      = '0;
         end
         i2dt_pkg::UNIT_DABBLE: begin
            bcd_in = {fixed[i2dt_pkg::BCD_BITS-2:0], bin_ff[i2dt_pkg::VALUE_BITS-1]};
            bin_in = {bin_ff[i2dt_pkg::VALUE_BITS-2:0], 1'b0};
         end
         i2dt_pkg::UNIT_NEXT_DIGIT: begin
            bcd_in = {bcd_ff[i2dt_pkg::BCD_BITS-5:0], 4'b0000};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      negative_ff <= negative_in;
   end

   assign status.top_digit = bcd_ff[i2dt_pkg::BCD_BITS-1 -: 4];
   assign status.negative  = negative_ff;

endmodule

@@ src/i2dt_ctrl.sv @@
// Sequencer that steps the shift unit, trims leading zeros and hands out one character per beat.
module i2dt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_char,
   output logic                        rsp_last_char,
   input  i2dt_pkg::unit_status_type   status,
   output i2dt_pkg::unit_op_type       op
);

   i2dt_pkg::state_type                 state_ff, state_in;
   logic [i2dt_pkg::BIT_CNT_BITS-1:0]   bits_ff, bits_in;
   logic [i2dt_pkg::DIG_CNT_BITS-1:0]   left_ff, left_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2dt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bits_ff <= bits_in;
      left_ff <= left_in;
   end

   always_comb begin
      state_in      = state_ff;
      bits_in       = bits_ff;
      left_in       = left_ff;
      op            = i2dt_pkg::UNIT_HOLD;
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      rsp_out_char  = i2dt_pkg::ASCII_ZERO + {4'b0000, status.top_digit};
      rsp_last_char = 1'b0;
      unique case (state_ff)
         i2dt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op       = i2dt_pkg::UNIT_LOAD;
               bits_in  = i2dt_pkg::BIT_CNT_BITS'(i2dt_pkg::VALUE_BITS);
               state_in = i2dt_pkg::ST_CONVERT;
            end
         end
         i2dt_pkg::ST_CONVERT: begin
            op      = i2dt_pkg::UNIT_DABBLE;
            bits_in = bits_ff - 1'b1;
            if (bits_ff == i2dt_pkg::BIT_CNT_BITS'(1)) begin
               left_in  = i2dt_pkg::DIG_CNT_BITS'(i2dt_pkg::DIGIT_COUNT);
               state_in = i2dt_pkg::ST_TRIM;
            end
         end
         i2dt_pkg::ST_TRIM: begin
            // Drop leading zero digits, but always keep the units digit.
            if (status.top_digit == 4'd0 && left_ff > i2dt_pkg::DIG_CNT_BITS'(1)) begin
               op      = i2dt_pkg::UNIT_NEXT_DIGIT;
               left_in = left_ff - 1'b1;
            end else if (status.negative) begin
               state_in = i2dt_pkg::ST_SIGN;
            end else begin
               state_in = i2dt_pkg::ST_DIGITS;
            end
         end
         i2dt_pkg::ST_SIGN: begin
            rsp_valid    = 1'b1;
            rsp_out_char = i2dt_pkg::ASCII_MINUS;
            if (!rsp_stall) begin
               state_in = i2dt_pkg::ST_DIGITS;
            end
         end
         i2dt_pkg::ST_DIGITS: begin
            rsp_valid     = 1'b1;
            rsp_last_char = (left_ff == i2dt_pkg::DIG_CNT_BITS'(1));
            if (!rsp_stall) begin
               op      = i2dt_pkg::UNIT_NEXT_DIGIT;
               left_in = left_ff - 1'b1;
               if (left_ff == i2dt_pkg::DIG_CNT_BITS'(1)) begin
                  state_in = i2dt_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = i2dt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/integer_to_decimal_text.sv @@
// Top level of the signed integer to decimal ASCII text converter.
//
//   channel   ports                             direction   beat
//   request   req_valid req_stall req_value     in          one signed integer
//   response  rsp_valid rsp_stall rsp_out_char  out         one character, most significant first
//             rsp_last_char
//
// An integer is loaded, shifted VALUE_BITS times through the shared double dabble
// unit, stripped of up to DIGIT_COUNT-1 leading zero digits and checked for sign, then
// handed out as a minus sign, if negative, and its digits, one character per beat while the response is not stalled.
// The request side is stalled after the accepting beat until the last character is taken.
// A response stall holds the current character and its last flag unchanged.
// Reset is synchronous and returns only the sequencer state to idle; the counters and shift unit are not reset.
module integer_to_decimal_text (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [i2dt_pkg::VALUE_BITS-1:0]  req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [7:0]                              rsp_out_char,
   output logic                                    rsp_last_char
);

   i2dt_pkg::unit_op_type      op;
   i2dt_pkg::unit_status_type  status;

   i2dt_shift_unit u_shift_unit (
      .clock      (clock),
      .op         (op),
      .load_value (req_value),
      .status     (status)
   );

   i2dt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .status        (status),
      .op            (op)
   );

endmodule
